// ----- design/fbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Field widths, register codes, result codes and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int SIZE_W     = 16;
   localparam int COUNT_W    = 9;
   localparam int ADDR_W     = 32;
   localparam int BYTES_W    = 24;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [SIZE_W-1:0]  MIN_BLOCK_SIZE   = 16'd8;
   localparam logic [BYTES_W-1:0] BYTES_MAX        = 24'hFFFFFF;
   localparam logic [SIZE_W-1:0]  RST_BLOCK_SIZE   = 16'd64;
   localparam logic [COUNT_W-1:0] RST_BLOCK_COUNT  = 9'd256;
   localparam logic [ADDR_W-1:0]  RST_BASE_ADDRESS = 32'h0000_1000;

   localparam int DIV_STEPS = ADDR_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      REG_BLOCK_SIZE   = 2'd0,
      REG_BLOCK_COUNT  = 2'd1,
      REG_BASE_ADDRESS = 2'd2
   } fbpa_reg_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK             = 3'd0,
      RSP_SIZE_TOO_LARGE = 3'd1,
      RSP_POOL_EMPTY     = 3'd2,
      RSP_NULL_IGNORED   = 3'd3,
      RSP_OUT_OF_RANGE   = 3'd4,
      RSP_MISALIGNED     = 3'd5
   } fbpa_status_type;

   typedef enum logic [1:0] {
      MUL_HEAD  = 2'd0,
      MUL_COUNT = 2'd1,
      MUL_USED  = 2'd2
   } fbpa_mul_sel_type;

   typedef struct packed {
      logic             sweep_clear;
      logic             sweep_step;
      logic             load;
      logic             mul_en;
      fbpa_mul_sel_type mul_sel;
      logic             pop;
      logic             div_start;
      logic             push;
      logic             set_status;
      fbpa_status_type  status;
      logic             out_load;
   } fbpa_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic mode_free;
      logic size_big;
      logic list_empty;
      logic addr_null;
      logic out_of_range;
      logic div_done;
      logic misaligned;
      logic out_busy;
   } fbpa_sts_type;

endpackage

// ----- design/fbpa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator channels
// Request and response channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   import fbpa_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic [ADDR_W-1:0] request_bytes;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, mode, request_bytes, block_address, input ready);
   modport sink (input valid, mode, request_bytes, block_address, output ready);
endinterface

interface fbpa_rsp_if;
   import fbpa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   granted_address;
   logic [BYTES_W-1:0]  bytes_in_use;

   modport source (output valid, status, granted_address, bytes_in_use, input ready);
   modport sink (input valid, status, granted_address, bytes_in_use, output ready);
endinterface

// ----- design/fbpa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator divider
// Restoring divider, one quotient bit per cycle, for offset / block size.
// ----------------------------------------------------------------------------
module fbpa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
   input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
   output logic [fbpa_pkg::ADDR_W-1:0] quotient,
   output logic [fbpa_pkg::SIZE_W-1:0] remainder,
   output logic                        done
);
   import fbpa_pkg::*;

   logic                 busy_ff;
   logic [DIV_CNT_W-1:0] step_ff;
   logic [ADDR_W-1:0]    quot_ff;
   logic [SIZE_W-1:0]    rem_ff;
   logic [SIZE_W:0]      part;
   logic [SIZE_W:0]      diff;

   assign part      = {rem_ff, quot_ff[ADDR_W-1]};
   assign diff      = part - {1'b0, divisor};
   assign done      = busy_ff && (step_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + DIV_CNT_W'(1);
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         if (!diff[SIZE_W]) begin
            rem_ff  <= diff[SIZE_W-1:0];
            quot_ff <= {quot_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_ff  <= part[SIZE_W-1:0];
            quot_ff <= {quot_ff[ADDR_W-2:0], 1'b0};
         end
      end
   end

endmodule

// ----- design/fbpa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Free-list link memory, list head and free count, multiplier, divider
// and the response output register.
// ----------------------------------------------------------------------------
module fbpa_dp #(
   parameter int POOL_ENTRIES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fbpa_pkg::fbpa_cmd_type       cmd,
   output fbpa_pkg::fbpa_sts_type       sts,
   input  logic [fbpa_pkg::SIZE_W-1:0]  block_size,
   input  logic [fbpa_pkg::COUNT_W-1:0] block_count,
   input  logic [fbpa_pkg::ADDR_W-1:0]  base_address,
   input  logic                         mode,
   input  logic [fbpa_pkg::ADDR_W-1:0]  request_bytes,
   input  logic [fbpa_pkg::ADDR_W-1:0]  block_address,
   fbpa_rsp_if.source                   rsp_ch
);
   import fbpa_pkg::*;

   localparam int IDX_W  = $clog2(POOL_ENTRIES);
   localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
   localparam int PROD_W = LINK_W + SIZE_W;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_ENTRIES);

   logic [LINK_W-1:0] link_mem [POOL_ENTRIES];
   logic [LINK_W-1:0] link_q_ff;
   logic              link_we;
   logic [IDX_W-1:0]  link_wa;
   logic [LINK_W-1:0] link_wd;

   logic [IDX_W-1:0]  sweep_cnt_ff;
   logic              sweep_last;
   logic [LINK_W-1:0] sweep_next;
   logic [LINK_W-1:0] sweep_link;

   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] free_ff;

   logic                 mode_ff;
   logic [ADDR_W-1:0]    request_ff;
   logic [ADDR_W-1:0]    offset_ff;
   logic                 addr_null_ff;
   fbpa_status_type      code_ff;
   logic [ADDR_W-1:0]    granted_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    prod_in;

   logic                 rsp_valid_ff;
   fbpa_status_type      rsp_status_ff;
   logic [ADDR_W-1:0]    rsp_granted_ff;
   logic [BYTES_W-1:0]   rsp_bytes_ff;
   logic [BYTES_W-1:0]   bytes_sat;

   logic [SIZE_W-1:0]    size_eff;
   logic [LINK_W-1:0]    count_eff;
   logic [LINK_W-1:0]    used;
   logic [LINK_W-1:0]    mul_a;

   logic [ADDR_W-1:0]    div_quot;
   logic [SIZE_W-1:0]    div_rem;
   logic                 div_done;

   assign size_eff  = (block_size < MIN_BLOCK_SIZE) ? MIN_BLOCK_SIZE : block_size;
   assign count_eff = (32'(block_count) > 32'(POOL_ENTRIES)) ? LINK_W'(POOL_ENTRIES)
                                                             : LINK_W'(block_count);
   assign used      = (count_eff > free_ff) ? (count_eff - free_ff) : '0;

   always_comb begin
      case (cmd.mul_sel)
         MUL_HEAD:  mul_a = head_ff;
         MUL_COUNT: mul_a = count_eff;
         MUL_USED:  mul_a = used;
         default:   mul_a = '0;
      endcase
   end

   assign prod_in   = PROD_W'(mul_a) * PROD_W'(size_eff);
   assign bytes_sat = (64'(prod_ff) > 64'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(prod_ff);

   assign sweep_last = (sweep_cnt_ff == IDX_W'(POOL_ENTRIES - 1));
   assign sweep_next = LINK_W'(sweep_cnt_ff) + LINK_W'(1);
   assign sweep_link = (sweep_next < count_eff) ? sweep_next : LINK_NULL;

   always_comb begin
      link_we = cmd.sweep_step | cmd.push;
      link_wa = cmd.push ? div_quot[IDX_W-1:0] : sweep_cnt_ff;
      link_wd = cmd.push ? head_ff : sweep_link;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q_ff <= link_mem[head_ff[IDX_W-1:0]];
   end

   fbpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (offset_ff),
      .divisor   (size_eff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
         head_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep_clear) begin
            sweep_cnt_ff <= '0;
         end else if (cmd.sweep_step && !sweep_last) begin
            sweep_cnt_ff <= sweep_cnt_ff + IDX_W'(1);
         end

         if (cmd.sweep_step) begin
            head_ff <= (count_eff != '0) ? '0 : LINK_NULL;
            free_ff <= count_eff;
         end else if (cmd.pop) begin
            head_ff <= link_q_ff;
            if (free_ff != '0) begin
               free_ff <= free_ff - LINK_W'(1);
            end
         end else if (cmd.push) begin
            head_ff <= LINK_W'(div_quot);
            if (free_ff < count_eff) begin
               free_ff <= free_ff + LINK_W'(1);
            end
         end

         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= mode;
         request_ff   <= request_bytes;
         offset_ff    <= block_address - base_address;
         addr_null_ff <= (block_address == '0);
         code_ff      <= RSP_OK;
         granted_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            code_ff <= cmd.status;
         end
         if (cmd.pop) begin
            granted_ff <= base_address + 32'(prod_ff);
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.out_load) begin
         rsp_status_ff  <= code_ff;
         rsp_granted_ff <= granted_ff;
         rsp_bytes_ff   <= bytes_sat;
      end
   end

   always_comb begin
      sts.sweep_last   = sweep_last;
      sts.mode_free    = mode_ff;
      sts.size_big     = (request_ff > 32'(size_eff));
      sts.list_empty   = (head_ff == LINK_NULL);
      sts.addr_null    = addr_null_ff;
      sts.out_of_range = (64'(offset_ff) >= 64'(prod_ff));
      sts.div_done     = div_done;
      sts.misaligned   = (div_rem != '0);
      sts.out_busy     = rsp_valid_ff && !rsp_ch.ready;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.granted_address = rsp_granted_ff;
   assign rsp_ch.bytes_in_use    = rsp_bytes_ff;

endmodule

// ----- design/fbpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences list rebuild, allocate and free steps over the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rebuild,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  fbpa_pkg::fbpa_sts_type sts,
   output fbpa_pkg::fbpa_cmd_type cmd
);
   import fbpa_pkg::*;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_DECIDE,
      S_ALLOC_POP,
      S_SPAN_CHK,
      S_DIV,
      S_CHECK,
      S_USE_MUL,
      S_USE_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;
   logic      req_ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!sts.mode_free) begin
               if (sts.size_big) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = RSP_SIZE_TOO_LARGE;
                  state_in       = S_USE_MUL;
               end else if (sts.list_empty) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = RSP_POOL_EMPTY;
                  state_in       = S_USE_MUL;
               end else begin
                  cmd.mul_en  = 1'b1;
                  cmd.mul_sel = MUL_HEAD;
                  state_in    = S_ALLOC_POP;
               end
            end else if (sts.addr_null) begin
               cmd.set_status = 1'b1;
               cmd.status     = RSP_NULL_IGNORED;
               state_in       = S_USE_MUL;
            end else begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = MUL_COUNT;
               state_in    = S_SPAN_CHK;
            end
         end
         S_ALLOC_POP: begin
            cmd.pop  = 1'b1;
            state_in = S_USE_MUL;
         end
         S_SPAN_CHK: begin
            if (sts.out_of_range) begin
               cmd.set_status = 1'b1;
               cmd.status     = RSP_OUT_OF_RANGE;
               state_in       = S_USE_MUL;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.misaligned) begin
               cmd.set_status = 1'b1;
               cmd.status     = RSP_MISALIGNED;
            end else begin
               cmd.push = 1'b1;
            end
            state_in = S_USE_MUL;
         end
         S_USE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_USED;
            state_in    = S_USE_OUT;
         end
         S_USE_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_SWEEP;
      endcase
      if (rebuild) begin
         cmd             = '0;
         cmd.sweep_clear = 1'b1;
         state_in        = S_SWEEP;
      end
      req_ready_in = (state_in == S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// ----- design/fixed_block_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Pool of equal blocks handed out from a LIFO free list, with APB setup.
// ----------------------------------------------------------------------------
// One request is in work at a time. An allocate passes the decide, pop,
// used-count multiply and output states. A request rejected at the size,
// empty-list or null check goes straight to multiply; a free rejected at
// the range check passes the range check state first. A free that passes
// the null and range checks also runs the 32-step restoring divider that
// turns the block offset into a block index. After reset and after every
// write to a defined register the free list is rebuilt by a pass over the
// link memory, one entry per cycle, while requests are held off. A finished
// response waits in an output register and lets the next request be taken.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
   parameter int POOL_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   fbpa_req_if.sink                        req_ch,
   fbpa_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fbpa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fbpa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fbpa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import fbpa_pkg::*;

   logic [SIZE_W-1:0]  block_size_ff;
   logic [COUNT_W-1:0] block_count_ff;
   logic [ADDR_W-1:0]  base_address_ff;

   logic         cfg_write;
   logic         wr_size;
   logic         wr_count;
   logic         wr_base;
   logic         rebuild;
   logic         req_ready;
   fbpa_cmd_type cmd;
   fbpa_sts_type sts;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      wr_size    = 1'b0;
      wr_count   = 1'b0;
      wr_base    = 1'b0;
      csr_prdata = '0;
      unique case (csr_paddr[CSR_ADDR_W-1:2])
         REG_BLOCK_SIZE: begin
            wr_size    = cfg_write;
            csr_prdata = CSR_DATA_W'(block_size_ff);
         end
         REG_BLOCK_COUNT: begin
            wr_count   = cfg_write;
            csr_prdata = CSR_DATA_W'(block_count_ff);
         end
         REG_BASE_ADDRESS: begin
            wr_base    = cfg_write;
            csr_prdata = CSR_DATA_W'(base_address_ff);
         end
         default: csr_prdata = '0;
      endcase
   end

   assign rebuild = wr_size | wr_count | wr_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff   <= RST_BLOCK_SIZE;
         block_count_ff  <= RST_BLOCK_COUNT;
         base_address_ff <= RST_BASE_ADDRESS;
      end else begin
         if (wr_size) begin
            block_size_ff <= csr_pwdata[SIZE_W-1:0];
         end
         if (wr_count) begin
            block_count_ff <= csr_pwdata[COUNT_W-1:0];
         end
         if (wr_base) begin
            base_address_ff <= csr_pwdata[ADDR_W-1:0];
         end
      end
   end

   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .rebuild   (rebuild),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_ch.ready = req_ready;

   fbpa_dp #(
      .POOL_ENTRIES (POOL_ENTRIES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .block_size    (block_size_ff),
      .block_count   (block_count_ff),
      .base_address  (base_address_ff),
      .mode          (req_ch.mode),
      .request_bytes (req_ch.request_bytes),
      .block_address (req_ch.block_address),
      .rsp_ch        (rsp_ch)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request taken while another is in work");

   a_rebuild_stall: assert property (@(posedge clock) disable iff (reset)
      rebuild |=> !req_ch.ready)
      else $error("request open during free list rebuild");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> !$past(req_ch.ready))
      else $error("response raised without a request in work");

endmodule
